FILE: rtl/core/lspc_pkg.sv
package lspc_pkg;

   localparam int LIMIT_WIDTH = 12;
   localparam int COUNT_WIDTH = 10;
   localparam int PROD_WIDTH  = 2 * LIMIT_WIDTH;
   localparam int STEP_WIDTH  = 4;
   localparam int OP_WIDTH    = 4;
   localparam int COND_WIDTH  = 3;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Microprogram step addresses.
   localparam logic [STEP_WIDTH-1:0] S_IDLE  = 4'd0;
   localparam logic [STEP_WIDTH-1:0] S_CLR   = 4'd1;
   localparam logic [STEP_WIDTH-1:0] S_CHECK = 4'd2;
   localparam logic [STEP_WIDTH-1:0] S_VREAD = 4'd3;
   localparam logic [STEP_WIDTH-1:0] S_VTEST = 4'd4;
   localparam logic [STEP_WIDTH-1:0] S_JTEST = 4'd5;
   localparam logic [STEP_WIDTH-1:0] S_MUL   = 4'd6;
   localparam logic [STEP_WIDTH-1:0] S_MARK  = 4'd7;
   localparam logic [STEP_WIDTH-1:0] S_VNEXT = 4'd8;
   localparam logic [STEP_WIDTH-1:0] S_DONE  = 4'd9;

   // Datapath operations.
   localparam logic [OP_WIDTH-1:0] OP_NOP   = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_LOAD  = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_START = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_RD_SF = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_PRIME = 4'd5;
   localparam logic [OP_WIDTH-1:0] OP_RD_P  = 4'd6;
   localparam logic [OP_WIDTH-1:0] OP_MUL   = 4'd7;
   localparam logic [OP_WIDTH-1:0] OP_MARK  = 4'd8;
   localparam logic [OP_WIDTH-1:0] OP_VNEXT = 4'd9;
   localparam logic [OP_WIDTH-1:0] OP_OUT   = 4'd10;

   // Jump conditions.
   localparam logic [COND_WIDTH-1:0] C_ALWAYS    = 3'd0;
   localparam logic [COND_WIDTH-1:0] C_NO_REQ    = 3'd1;
   localparam logic [COND_WIDTH-1:0] C_CLR_MORE  = 3'd2;
   localparam logic [COND_WIDTH-1:0] C_LIM_SMALL = 3'd3;
   localparam logic [COND_WIDTH-1:0] C_J_END     = 3'd4;
   localparam logic [COND_WIDTH-1:0] C_BREAK     = 3'd5;
   localparam logic [COND_WIDTH-1:0] C_V_LAST    = 3'd6;
   localparam logic [COND_WIDTH-1:0] C_OUT_BUSY  = 3'd7;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [COND_WIDTH-1:0] cond;
      logic [STEP_WIDTH-1:0] hit;
      logic [STEP_WIDTH-1:0] miss;
   } ctrl_word_type;

   function automatic ctrl_word_type micro_rom(input logic [STEP_WIDTH-1:0] step);
      ctrl_word_type w;
      case (step)
         S_IDLE:  w = '{OP_LOAD,  C_NO_REQ,    S_IDLE,  S_CLR};
         S_CLR:   w = '{OP_CLEAR, C_CLR_MORE,  S_CLR,   S_CHECK};
         S_CHECK: w = '{OP_START, C_LIM_SMALL, S_DONE,  S_VREAD};
         S_VREAD: w = '{OP_RD_SF, C_ALWAYS,    S_VTEST, S_VTEST};
         S_VTEST: w = '{OP_PRIME, C_ALWAYS,    S_JTEST, S_JTEST};
         S_JTEST: w = '{OP_RD_P,  C_J_END,     S_VNEXT, S_MUL};
         S_MUL:   w = '{OP_MUL,   C_ALWAYS,    S_MARK,  S_MARK};
         S_MARK:  w = '{OP_MARK,  C_BREAK,     S_VNEXT, S_JTEST};
         S_VNEXT: w = '{OP_VNEXT, C_V_LAST,    S_DONE,  S_VREAD};
         S_DONE:  w = '{OP_OUT,   C_OUT_BUSY,  S_DONE,  S_IDLE};
         default: w = '{OP_NOP,   C_ALWAYS,    S_IDLE,  S_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/linear_sieve_prime_counter.sv
// Counts the primes not greater than the limit in each request word, using Euler's linear
// sieve over an on-chip smallest-factor memory, and returns the count in one response word.
// A request is taken only when the sequencer is idle; a finished count waits in the output
// register while the next request is accepted. A run first clears the table entries 0 to
// limit, then for each value from 2 to the limit reads its smallest factor, records it if
// prime and marks the composites it produces; a limit below two skips the sieve. The
// factor memory is used as a single port, and the microprogram issues one control word
// per cycle.
module linear_sieve_prime_counter #(
   parameter int TABLE_DEPTH = 4096,
   parameter int PRIME_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lspc_pkg::LIMIT_WIDTH-1:0]   req_limit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lspc_pkg::COUNT_WIDTH-1:0]   rsp_prime_count
);
   import lspc_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = $clog2(PRIME_DEPTH);
   localparam int SW = $clog2(PRIME_DEPTH + 1);
   localparam int CAP_INT = ((TABLE_DEPTH - 1) < (2 ** LIMIT_WIDTH - 1)) ?
                            (TABLE_DEPTH - 1) : (2 ** LIMIT_WIDTH - 1);
   localparam logic [LIMIT_WIDTH-1:0] LIM_CAP    = LIMIT_WIDTH'(CAP_INT);
   localparam logic [SW-1:0]          STORE_FULL = SW'(PRIME_DEPTH);

   logic [STEP_WIDTH-1:0]  upc_ff, upc_in;
   logic [LIMIT_WIDTH-1:0] lim_ff, lim_in;
   logic [LIMIT_WIDTH-1:0] v_ff, v_in;
   logic [SW-1:0]          j_ff, j_in;
   logic [LIMIT_WIDTH-1:0] sf_ff, sf_in;
   logic [LIMIT_WIDTH-1:0] p_ff, p_in;
   logic [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic [SW-1:0]          stored_ff, stored_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic [LIMIT_WIDTH-1:0] sf_rd_ff;
   logic [LIMIT_WIDTH-1:0] p_rd_ff;

   logic [LIMIT_WIDTH-1:0] sf_mem [TABLE_DEPTH];
   logic [LIMIT_WIDTH-1:0] prime_mem [PRIME_DEPTH];

   ctrl_word_type          cw;
   logic                   req_accept;
   logic                   brk;
   logic                   v_last;
   logic                   out_busy;
   logic                   j_end;
   logic                   cond_hit;
   logic                   is_prime;
   logic                   sf_we;
   logic [AW-1:0]          sf_waddr;
   logic [LIMIT_WIDTH-1:0] sf_wdata;
   logic                   sf_re;
   logic                   pl_we;
   logic                   pl_re;

   assign cw         = micro_rom(upc_ff);
   assign req_ready  = (upc_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign brk        = (p_ff > sf_ff) || (prod_ff > PROD_WIDTH'(lim_ff));
   assign v_last     = (v_ff == lim_ff);
   assign out_busy   = rsp_valid_ff && !rsp_ready;
   assign j_end      = (j_ff == stored_ff);
   assign is_prime   = (sf_rd_ff == '0);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;

   always_comb begin
      case (cw.cond)
         C_ALWAYS:    cond_hit = 1'b1;
         C_NO_REQ:    cond_hit = !req_accept;
         C_CLR_MORE:  cond_hit = !v_last;
         C_LIM_SMALL: cond_hit = (lim_ff < LIMIT_WIDTH'(2));
         C_J_END:     cond_hit = j_end;
         C_BREAK:     cond_hit = brk;
         C_V_LAST:    cond_hit = v_last;
         C_OUT_BUSY:  cond_hit = out_busy;
         default:     cond_hit = 1'b1;
      endcase
   end

   always_comb begin
      upc_in       = cond_hit ? cw.hit : cw.miss;
      lim_in       = lim_ff;
      v_in         = v_ff;
      j_in         = j_ff;
      sf_in        = sf_ff;
      p_in         = p_ff;
      prod_in      = prod_ff;
      stored_in    = stored_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      sf_we        = 1'b0;
      sf_waddr     = AW'(v_ff);
      sf_wdata     = '0;
      sf_re        = 1'b0;
      pl_we        = 1'b0;
      pl_re        = 1'b0;
      case (cw.op)
         OP_LOAD: begin
            if (req_accept) begin
               lim_in    = (req_limit > LIM_CAP) ? LIM_CAP : req_limit;
               v_in      = '0;
               stored_in = '0;
               count_in  = '0;
            end
         end
         OP_CLEAR: begin
            sf_we = 1'b1;
            v_in  = v_ff + 1'b1;
         end
         OP_START: begin
            v_in = LIMIT_WIDTH'(2);
         end
         OP_RD_SF: begin
            sf_re = 1'b1;
         end
         OP_PRIME: begin
            j_in = '0;
            if (is_prime) begin
               sf_in    = v_ff;
               sf_we    = 1'b1;
               sf_wdata = v_ff;
               if (stored_ff != STORE_FULL) begin
                  pl_we     = 1'b1;
                  stored_in = stored_ff + 1'b1;
               end
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               sf_in = sf_rd_ff;
            end
         end
         OP_RD_P: begin
            pl_re = !j_end;
         end
         OP_MUL: begin
            prod_in = PROD_WIDTH'(v_ff) * PROD_WIDTH'(p_rd_ff);
            p_in    = p_rd_ff;
         end
         OP_MARK: begin
            if (!brk) begin
               sf_we    = 1'b1;
               sf_waddr = AW'(prod_ff[LIMIT_WIDTH-1:0]);
               sf_wdata = p_ff;
               j_in     = j_ff + 1'b1;
            end
         end
         OP_VNEXT: begin
            if (!v_last) begin
               v_in = v_ff + 1'b1;
            end
         end
         OP_OUT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (sf_we) begin
         sf_mem[sf_waddr] <= sf_wdata;
      end
      if (sf_re) begin
         sf_rd_ff <= sf_mem[AW'(v_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (pl_we) begin
         prime_mem[stored_ff[PW-1:0]] <= v_ff;
      end
      if (pl_re) begin
         p_rd_ff <= prime_mem[j_ff[PW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         stored_ff    <= '0;
         count_ff     <= '0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         stored_ff    <= stored_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff       <= lim_in;
      v_ff         <= v_in;
      j_ff         <= j_in;
      sf_ff        <= sf_in;
      p_ff         <= p_in;
      prod_ff      <= prod_in;
      rsp_count_ff <= rsp_count_in;
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upc_ff) == S_DONE)
      else $error("Response word raised outside the final step.");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == S_MARK && !brk) |-> prod_ff <= PROD_WIDTH'(lim_ff))
      else $error("Factor mark written beyond the limit.");

   a_stored_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= STORE_FULL)
      else $error("Prime list fill exceeds its depth.");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == S_VTEST) |-> (v_ff >= LIMIT_WIDTH'(2) && v_ff <= lim_ff))
      else $error("Sieved value outside two to the limit.");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= S_DONE)
      else $error("Sequencer left the microprogram.");

endmodule

FILE: tb/prime_count_monitor.sv
module prime_count_monitor #(
   parameter int TABLE_DEPTH = 4096,
   parameter int PRIME_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [lspc_pkg::LIMIT_WIDTH-1:0] req_limit,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [lspc_pkg::COUNT_WIDTH-1:0] rsp_prime_count,
   output int                               fail_count,
   output int                               pending
);
   import lspc_pkg::*;

   logic [COUNT_WIDTH-1:0] expected_counts [$];
   int mismatch_total = 0;
   int in_flight = 0;

   assign fail_count = mismatch_total;
   assign pending    = in_flight;

   function automatic logic [COUNT_WIDTH-1:0] count_primes_upto(
      input logic [LIMIT_WIDTH-1:0] lim_in
   );
      logic [LIMIT_WIDTH-1:0] factor_of [TABLE_DEPTH];
      logic [LIMIT_WIDTH-1:0] primes [PRIME_DEPTH];
      int unsigned lim;
      int unsigned stored;
      int unsigned found;
      int unsigned sf;
      int unsigned p;
      int unsigned prod;
      lim = 32'(lim_in);
      if (lim > TABLE_DEPTH - 1) begin
         lim = TABLE_DEPTH - 1;
      end
      stored = 0;
      found  = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         factor_of[i] = '0;
      end
      for (int unsigned v = 2; v <= lim; v++) begin
         if (factor_of[v] == '0) begin
            factor_of[v] = LIMIT_WIDTH'(v);
            if (stored < PRIME_DEPTH) begin
               primes[stored] = LIMIT_WIDTH'(v);
               stored++;
            end
            if (found < COUNT_MAX) begin
               found++;
            end
         end
         sf = 32'(factor_of[v]);
         for (int unsigned j = 0; j < stored; j++) begin
            p    = 32'(primes[j]);
            prod = v * p;
            if (p > sf || prod > lim) begin
               break;
            end
            factor_of[prod] = LIMIT_WIDTH'(p);
         end
      end
      return COUNT_WIDTH'(found);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: prime count mismatch: %s", $time, what);
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_counts = {expected_counts, count_primes_upto(req_limit)};
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("unexpected word with count %0d", rsp_prime_count));
            end else begin
               if (rsp_prime_count !== expected_counts[0]) begin
                  report_mismatch($sformatf("got %0d, expected %0d",
                                            rsp_prime_count, expected_counts[0]));
               end
               void'(expected_counts.pop_front());
            end
         end
         in_flight <= expected_counts.size();
      end
   end

endmodule

FILE: tb/tb.sv
module tb;
   import lspc_pkg::*;

   localparam int IDLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 76;
   localparam int DIRECTED_WORDS = 24;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [LIMIT_WIDTH-1:0] req_limit = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [COUNT_WIDTH-1:0] rsp_prime_count;

   int fail_count;
   int pending;
   int burst_left = 0;
   int ready_mode = 0;
   int ready_left = 0;
   int idle_cycles = 0;

   logic [LIMIT_WIDTH-1:0] directed_limits [0:DIRECTED_WORDS-1] = '{
      12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6, 12'd7,
      12'd8, 12'd9, 12'd10, 12'd11, 12'd12, 12'd25, 12'd31, 12'd32,
      12'd49, 12'd97, 12'd1024, 12'h555, 12'd2047, 12'd2048, 12'haaa, 12'd4095
   };

   linear_sieve_prime_counter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_limit       (req_limit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_count (rsp_prime_count)
   );

   prime_count_monitor count_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_limit       (req_limit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_count (rsp_prime_count),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Words go out in bursts; between bursts the valid line drops for a random gap.
   task automatic send_limit(input logic [LIMIT_WIDTH-1:0] lim);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_limit <= lim;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(1, 100);
      end
      ready_left--;
      case (ready_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 7) == 0);
         end
         default: begin
            rsp_ready <= 1'b0;
         end
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("linear_sieve_prime_counter regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int sel;
      logic [LIMIT_WIDTH-1:0] lim;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIRECTED_WORDS; i++) begin
         send_limit(directed_limits[i]);
      end
      // Mostly short runs, with full-range limits rare, so that the run stays brief.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 80) begin
            lim = LIMIT_WIDTH'($urandom_range(0, 127));
         end else if (sel < 92) begin
            lim = LIMIT_WIDTH'($urandom_range(0, 1023));
         end else begin
            lim = LIMIT_WIDTH'($urandom_range(0, 4095));
         end
         send_limit(lim);
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("linear_sieve_prime_counter regression: pass");
      end else begin
         $display("linear_sieve_prime_counter regression: fail");
      end
      $finish;
   end

endmodule
